/* hdl/bps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BPS patch applier package
// Shared types, codes and the byte-wise CRC-32 step.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned SRC_DEPTH_DEF = 1048576;
  localparam int unsigned TGT_DEPTH_DEF = 1048576;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_HDR   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_CRC   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PATCH = 2'd1,
    OP_READ  = 2'd2,
    OP_RUN   = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  data;
    logic [19:0] addr;
    logic        rd_ok;
  } item_t;

  typedef struct packed {
    logic [1:0] err;
    logic       fin;
    logic       run;
  } stat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    unique case (idx)
      2'd0: m = 8'h42;
      2'd1: m = 8'h50;
      2'd2: m = 8'h53;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* hdl/bps_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BPS front end
// Takes input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module bps_front #(
  parameter int unsigned TARGET_DEPTH = bps_pkg::TGT_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    mode_i,
  input  wire logic [7:0]    byte_value_i,
  input  wire logic [19:0]   address_i,
  output logic               q_valid_o,
  output bps_pkg::item_t     q_item_o,
  input  wire logic          q_pop_i
);
  import bps_pkg::*;

  item_t      q_mem [2];
  item_t      item_in;
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  always_comb begin
    item_in.op    = op_e'(mode_i);
    item_in.data  = byte_value_i;
    item_in.addr  = address_i;
    item_in.rd_ok = 25'(address_i) < 25'(TARGET_DEPTH);
    full      = cnt_q == 2'd2;
    q_valid_o = cnt_q != 2'd0;
    q_item_o  = q_mem[rd_ptr_q];
    wr_en     = push && !full;
    rd_en     = q_pop_i && q_valid_o;
    wr_ptr_d  = wr_en ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d  = rd_en ? !rd_ptr_q : rd_ptr_q;
    cnt_d     = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      q_mem[wr_ptr_q] <= item_in;
    end
  end

endmodule
`default_nettype wire

/* hdl/bps_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BPS back end
// Parses the patch stream, runs copy commands into the target store, checks
// the trailing CRCs and holds the result register.
// ----------------------------------------------------------------------------
module bps_back #(
  parameter int unsigned SOURCE_DEPTH = bps_pkg::SRC_DEPTH_DEF,
  parameter int unsigned TARGET_DEPTH = bps_pkg::TGT_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  bps_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  input  wire logic          cfg_we_i,
  input  wire logic [23:0]   cfg_wdata_i,
  input  wire logic          pop_i,
  output logic               out_valid_o,
  output logic [7:0]         read_data_o,
  output logic [1:0]         status_o,
  output logic               done_res_o,
  output bps_pkg::stat_t     stat_o
);
  import bps_pkg::*;

  localparam int unsigned SAW = $clog2(SOURCE_DEPTH);
  localparam int unsigned TAW = $clog2(TARGET_DEPTH);
  localparam int unsigned SCW = $clog2(SOURCE_DEPTH + 1);
  localparam int unsigned TPW = $clog2(TARGET_DEPTH + 1);
  localparam int unsigned AW  = (SAW > TAW) ? SAW : TAW;

  localparam logic [3:0] PH_MAGIC   = 4'd0;
  localparam logic [3:0] PH_SRCSIZE = 4'd1;
  localparam logic [3:0] PH_TGTSIZE = 4'd2;
  localparam logic [3:0] PH_META    = 4'd3;
  localparam logic [3:0] PH_SKIP    = 4'd4;
  localparam logic [3:0] PH_CMD     = 4'd5;
  localparam logic [3:0] PH_LITERAL = 4'd6;
  localparam logic [3:0] PH_OFFSET  = 4'd7;
  localparam logic [3:0] PH_FIN     = 4'd8;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EXEC = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_CPRD = 4'd4;
  localparam logic [3:0] S_CPWR = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_TAIL = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  localparam logic [1:0] CMD_SRC_READ = 2'd0;
  localparam logic [1:0] CMD_TGT_READ = 2'd1;
  localparam logic [1:0] CMD_SRC_COPY = 2'd2;

  function automatic logic [1:0] set_err(input logic [1:0] cur, input logic [1:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  logic [7:0] src_mem [SOURCE_DEPTH];
  logic [7:0] tgt_mem [TARGET_DEPTH];

  // control state
  logic [3:0]     state_q, state_d;
  logic [3:0]     phase_q, phase_d;
  logic [23:0]    plen_q, plen_d;
  logic [23:0]    pc_q, pc_d;
  logic [SCW-1:0] sc_q, sc_d;
  logic [TPW-1:0] tp_q, tp_d;
  logic [TPW-1:0] ts_q, ts_d;
  logic [SCW-1:0] srel_q, srel_d;
  logic [TPW-1:0] trel_q, trel_d;
  logic [63:0]    vval_q, vval_d;
  logic [3:0]     vk_q, vk_d;
  logic [1:0]     cmd_q, cmd_d;
  logic [TPW-1:0] pend_q, pend_d;
  logic [23:0]    ml_q, ml_d;
  logic [31:0]    crc_q [3];
  logic [31:0]    crc_d [3];
  logic [31:0]    chk_q [3];
  logic [31:0]    chk_d [3];
  logic [1:0]     err_q, err_d;
  logic           out_v_q, out_v_d;

  // payload
  item_t          item_q, item_d;
  logic [63:0]    v_q, v_d;
  logic [33:0]    start_q, start_d;
  logic [AW-1:0]  cp_addr_q, cp_addr_d;
  logic           cp_tgt_q, cp_tgt_d;
  logic [TPW-1:0] tail_q, tail_d;
  logic [31:0]    tcrc_q, tcrc_d;
  logic [7:0]     src_rd_q, tgt_rd_q;
  logic [7:0]     out_rd_q;
  logic [1:0]     out_st_q;
  logic           out_done_q;

  // memory ports
  logic           src_we, src_re, tgt_we, tgt_re;
  logic [SAW-1:0] src_raddr;
  logic [TAW-1:0] tgt_addr;
  logic [7:0]     tgt_wdata;
  logic           out_load;

  // datapath temporaries
  logic [7:0]     x, vbyte, cp_byte;
  logic [6:0]     vshamt;
  logic [63:0]    vadd, vnew, len64, mag;
  logic [24:0]    pc_ext, plen_ext, kfull;
  logic [3:0]     kk;
  logic [TPW-1:0] room;
  logic [33:0]    base;
  logic [34:0]    end_addr;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    plen_d    = plen_q;
    pc_d      = pc_q;
    sc_d      = sc_q;
    tp_d      = tp_q;
    ts_d      = ts_q;
    srel_d    = srel_q;
    trel_d    = trel_q;
    vval_d    = vval_q;
    vk_d      = vk_q;
    cmd_d     = cmd_q;
    pend_d    = pend_q;
    ml_d      = ml_q;
    crc_d     = crc_q;
    chk_d     = chk_q;
    err_d     = err_q;
    item_d    = item_q;
    v_d       = v_q;
    start_d   = start_q;
    cp_addr_d = cp_addr_q;
    cp_tgt_d  = cp_tgt_q;
    tail_d    = tail_q;
    tcrc_d    = tcrc_q;
    q_pop_o   = 1'b0;
    src_we    = 1'b0;
    src_re    = 1'b0;
    src_raddr = SAW'(cp_addr_q);
    tgt_we    = 1'b0;
    tgt_re    = 1'b0;
    tgt_addr  = tp_q[TAW-1:0];
    tgt_wdata = item_q.data;
    out_load  = 1'b0;

    x        = item_q.data;
    vbyte    = {~x[7], x[6:0]};
    vshamt   = 7'(vk_q) * 7'd7;
    vadd     = (vk_q > 4'd9) ? 64'd0 : (64'(vbyte) << vshamt);
    vnew     = vval_q + vadd;
    pc_ext   = {1'b0, pc_q};
    plen_ext = {1'b0, plen_q};
    kfull    = pc_ext + 25'd12 - plen_ext;
    kk       = kfull[3:0];
    len64    = (v_q >> 2) + 64'd1;
    mag      = v_q >> 1;
    room     = ts_q - tp_q;
    base     = (cmd_q == CMD_SRC_COPY) ? 34'(srel_q) : 34'(trel_q);
    end_addr = 35'(start_q) + 35'(pend_q);
    cp_byte  = cp_tgt_q ? tgt_rd_q : src_rd_q;

    if (cfg_we_i) begin
      plen_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_EMIT;
        unique case (item_q.op)
          OP_LOAD: begin
            if (sc_q >= SCW'(SOURCE_DEPTH)) begin
              err_d = set_err(err_q, ST_RANGE);
            end else begin
              src_we   = 1'b1;
              sc_d     = sc_q + 1'b1;
              crc_d[0] = crc_byte(crc_q[0], x);
            end
          end
          OP_PATCH: begin
            if (phase_q != PH_FIN && pc_q < plen_q) begin
              pc_d = pc_q + 24'd1;
              if (pc_ext + 25'd4 < plen_ext) begin
                crc_d[2] = crc_byte(crc_q[2], x);
              end
              if (pc_ext + 25'd12 < plen_ext) begin
                if (err_q == ST_OK) begin
                  unique case (phase_q) inside
                    PH_MAGIC: begin
                      if (x != magic_byte(pc_q[1:0])) begin
                        err_d = set_err(err_q, ST_HDR);
                      end else if (pc_q == 24'd3) begin
                        phase_d = PH_SRCSIZE;
                      end
                    end
                    PH_SRCSIZE, PH_TGTSIZE, PH_META, PH_CMD, PH_OFFSET: begin
                      if (x[7]) begin
                        v_d     = vnew;
                        vval_d  = 64'd0;
                        vk_d    = 4'd0;
                        state_d = S_DEC;
                      end else begin
                        vval_d = vnew;
                        vk_d   = (vk_q > 4'd9) ? vk_q : vk_q + 4'd1;
                      end
                    end
                    PH_SKIP: begin
                      ml_d = ml_q - 24'd1;
                      if (ml_q == 24'd1) begin
                        phase_d = PH_CMD;
                      end
                    end
                    PH_LITERAL: begin
                      tgt_we   = 1'b1;
                      crc_d[1] = crc_byte(crc_q[1], x);
                      tp_d     = tp_q + 1'b1;
                      pend_d   = pend_q - 1'b1;
                      if (pend_q == TPW'(1)) begin
                        phase_d = PH_CMD;
                      end
                    end
                    default: ;
                  endcase
                end
              end else begin
                chk_d[kk[3:2]] = chk_q[kk[3:2]] | (32'(x) << {kk[1:0], 3'b000});
              end
              if (pc_ext + 25'd1 == plen_ext) begin
                state_d = S_FIN;
              end
            end
          end
          OP_READ: begin
            tgt_re   = item_q.rd_ok;
            tgt_addr = TAW'(item_q.addr);
          end
          default: begin
            sc_d    = '0;
            pc_d    = '0;
            tp_d    = '0;
            srel_d  = '0;
            trel_d  = '0;
            vval_d  = '0;
            vk_d    = '0;
            phase_d = PH_MAGIC;
            cmd_d   = '0;
            pend_d  = '0;
            ts_d    = '0;
            ml_d    = '0;
            err_d   = ST_OK;
            for (int i = 0; i < 3; i++) begin
              crc_d[i] = 32'hFFFF_FFFF;
              chk_d[i] = 32'd0;
            end
          end
        endcase
      end
      S_DEC: begin
        state_d = S_EMIT;
        unique case (phase_q) inside
          PH_SRCSIZE: phase_d = PH_TGTSIZE;
          PH_TGTSIZE: begin
            if (v_q > 64'(TARGET_DEPTH)) begin
              err_d = set_err(err_q, ST_RANGE);
            end else begin
              ts_d    = TPW'(v_q);
              phase_d = PH_META;
            end
          end
          PH_META: begin
            if (v_q == 64'd0) begin
              phase_d = PH_CMD;
            end else begin
              ml_d    = (v_q > 64'hFF_FFFF) ? 24'hFF_FFFF : v_q[23:0];
              phase_d = PH_SKIP;
            end
          end
          PH_CMD: begin
            if (len64 > 64'(room)) begin
              err_d = set_err(err_q, ST_RANGE);
            end else begin
              cmd_d  = v_q[1:0];
              pend_d = TPW'(len64);
              if (v_q[1:0] == CMD_SRC_READ) begin
                if (64'(tp_q) + len64 > 64'(sc_q)) begin
                  err_d = set_err(err_q, ST_RANGE);
                end else begin
                  cp_tgt_d  = 1'b0;
                  cp_addr_d = AW'(tp_q);
                  state_d   = S_CPRD;
                end
              end else if (v_q[1:0] == CMD_TGT_READ) begin
                phase_d = PH_LITERAL;
              end else begin
                phase_d = PH_OFFSET;
              end
            end
          end
          default: begin
            if (v_q[0]) begin
              if (mag > 64'(base)) begin
                err_d = set_err(err_q, ST_RANGE);
              end else begin
                start_d = base - mag[33:0];
                state_d = S_CHK;
              end
            end else begin
              if (mag > 64'hFFFF_FFFF) begin
                err_d = set_err(err_q, ST_RANGE);
              end else begin
                start_d = base + mag[33:0];
                state_d = S_CHK;
              end
            end
          end
        endcase
      end
      S_CHK: begin
        state_d = S_EMIT;
        if (cmd_q == CMD_SRC_COPY) begin
          if (end_addr > 35'(sc_q)) begin
            err_d = set_err(err_q, ST_RANGE);
          end else begin
            srel_d    = SCW'(end_addr);
            cp_tgt_d  = 1'b0;
            cp_addr_d = AW'(start_q);
            phase_d   = PH_CMD;
            state_d   = S_CPRD;
          end
        end else begin
          if (start_q >= 34'(tp_q)) begin
            err_d = set_err(err_q, ST_RANGE);
          end else begin
            trel_d    = TPW'(end_addr);
            cp_tgt_d  = 1'b1;
            cp_addr_d = AW'(start_q);
            phase_d   = PH_CMD;
            state_d   = S_CPRD;
          end
        end
      end
      S_CPRD: begin
        src_re   = !cp_tgt_q;
        tgt_re   = cp_tgt_q;
        tgt_addr = TAW'(cp_addr_q);
        state_d  = S_CPWR;
      end
      S_CPWR: begin
        tgt_we    = 1'b1;
        tgt_wdata = cp_byte;
        crc_d[1]  = crc_byte(crc_q[1], cp_byte);
        tp_d      = tp_q + 1'b1;
        cp_addr_d = cp_addr_q + 1'b1;
        pend_d    = pend_q - 1'b1;
        state_d   = (pend_q == TPW'(1)) ? S_EMIT : S_CPRD;
      end
      S_FIN: begin
        if (phase_q < PH_CMD) begin
          err_d = set_err(err_q, ST_HDR);
        end else if (phase_q != PH_CMD || vk_q != 4'd0) begin
          err_d = set_err(err_q, ST_RANGE);
        end
        tail_d  = tp_q;
        tcrc_d  = crc_q[1];
        state_d = S_TAIL;
      end
      S_TAIL: begin
        if (tail_q < ts_q) begin
          tcrc_d = crc_byte(tcrc_q, 8'd0);
          tail_d = tail_q + 1'b1;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (chk_q[0] != ~crc_q[0] || chk_q[1] != ~tcrc_q || chk_q[2] != ~crc_q[2]) begin
          err_d = set_err(err_q, ST_CRC);
        end
        phase_d = PH_FIN;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_v_q || pop_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_v_d = out_load ? 1'b1 : (pop_i ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_MAGIC;
      plen_q  <= '0;
      pc_q    <= '0;
      sc_q    <= '0;
      tp_q    <= '0;
      ts_q    <= '0;
      srel_q  <= '0;
      trel_q  <= '0;
      vval_q  <= '0;
      vk_q    <= '0;
      cmd_q   <= '0;
      pend_q  <= '0;
      ml_q    <= '0;
      err_q   <= ST_OK;
      out_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        crc_q[i] <= 32'hFFFF_FFFF;
        chk_q[i] <= 32'd0;
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      plen_q  <= plen_d;
      pc_q    <= pc_d;
      sc_q    <= sc_d;
      tp_q    <= tp_d;
      ts_q    <= ts_d;
      srel_q  <= srel_d;
      trel_q  <= trel_d;
      vval_q  <= vval_d;
      vk_q    <= vk_d;
      cmd_q   <= cmd_d;
      pend_q  <= pend_d;
      ml_q    <= ml_d;
      err_q   <= err_d;
      out_v_q <= out_v_d;
      crc_q   <= crc_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    v_q       <= v_d;
    start_q   <= start_d;
    cp_addr_q <= cp_addr_d;
    cp_tgt_q  <= cp_tgt_d;
    tail_q    <= tail_d;
    tcrc_q    <= tcrc_d;
    if (out_load) begin
      out_rd_q   <= (item_q.op == OP_READ && item_q.rd_ok) ? tgt_rd_q : 8'd0;
      out_st_q   <= err_q;
      out_done_q <= phase_q == PH_FIN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[sc_q[SAW-1:0]] <= x;
    end
    if (src_re) begin
      src_rd_q <= src_mem[src_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      tgt_mem[tgt_addr] <= tgt_wdata;
    end
    if (tgt_re) begin
      tgt_rd_q <= tgt_mem[tgt_addr];
    end
  end

  assign out_valid_o = out_v_q;
  assign read_data_o = out_rd_q;
  assign status_o    = out_st_q;
  assign done_res_o  = out_done_q;
  assign stat_o.err  = err_q;
  assign stat_o.fin  = phase_q == PH_FIN;
  assign stat_o.run  = state_q == S_EXEC && item_q.op == OP_RUN;

endmodule
`default_nettype wire

/* hdl/bps_patch_applier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// BPS patch applier
// Loads source bytes, applies a BPS patch stream into a target store and
// checks the three trailing CRC-32 words.
//
// Input is a queue: drive mode_i/byte_value_i/address_i with push while full
// is low. Mode 0 loads a source byte, 1 feeds a patch byte, 2 reads a target
// byte, 3 starts a new run. Results come out of a one-beat register: while
// empty is low read_data_o/status_o/done_res_o hold the oldest result, taken
// with pop. Every input beat yields exactly one result beat, in order.
// patch_length is written through cfg_we_i/cfg_wdata_i only while the block
// idles; the user must keep to this, the block itself does not enforce it.
// A copy command reads, then writes each target byte (one port on the target
// store); on the last patch byte the unwritten tail bytes are folded into the
// target CRC before the check. A two-beat input queue keeps accepting while
// the core works; a stalled result register halts the core until popped.
// Reset clears control counters and CRCs, not payload registers or stores.
// ----------------------------------------------------------------------------
module bps_patch_applier #(
  parameter int unsigned SOURCE_DEPTH = bps_pkg::SRC_DEPTH_DEF,
  parameter int unsigned TARGET_DEPTH = bps_pkg::TGT_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [19:0] address_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       read_data_o,
  output logic [1:0]       status_o,
  output logic             done_res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i
);
  import bps_pkg::*;

  item_t q_item;
  logic  q_valid, q_pop, out_valid;
  stat_t stat;

  bps_front #(
    .TARGET_DEPTH(TARGET_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .mode_i      (mode_i),
    .byte_value_i(byte_value_i),
    .address_i   (address_i),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  bps_back #(
    .SOURCE_DEPTH(SOURCE_DEPTH),
    .TARGET_DEPTH(TARGET_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_item),
    .q_pop_o    (q_pop),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pop_i      (pop),
    .out_valid_o(out_valid),
    .read_data_o(read_data_o),
    .status_o   (status_o),
    .done_res_o (done_res_o),
    .stat_o     (stat)
  );

  assign empty = !out_valid;

  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("core popped an empty queue");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.err != ST_OK && !stat.run) |=> stat.err == $past(stat.err))
    else $error("error code changed without a new run");

  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.fin && !stat.run) |=> stat.fin)
    else $error("finished state left without a new run");

endmodule
`default_nettype wire
